@@ rtl/adaptive_delta_pcm_decoder_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ADPCM-B decoder
// Clocked, reset-qualified concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_DELTA_PCM_DECODER_MACROS_SVH
`define ADAPTIVE_DELTA_PCM_DECODER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ADPCMB_ASSERT_ALWAYS(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADPCMB_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/adpcmb_pkg.sv @@
// ---------------------------------------------------------------------------
// adpcmb_pkg
// Types, constants and the step factor table of the ADPCM-B decoder.
// ---------------------------------------------------------------------------
package adpcmb_pkg;

    localparam logic [14:0] STEP_MIN = 15'd127;
    localparam logic [14:0] STEP_MAX = 15'd24576;

    // Configuration register indexes
    localparam logic [1:0] REG_STEREO_MODE  = 2'd0;
    localparam logic [1:0] REG_VOLUME_LEFT  = 2'd1;
    localparam logic [1:0] REG_VOLUME_RIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_block;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_first;
        logic signed [15:0] sample_second;
        logic signed [23:0] scaled_first;
        logic signed [23:0] scaled_second;
        logic               block_done;
    } out_item_t;

    // Per-channel decoder state
    typedef struct packed {
        logic signed [15:0] pred;
        logic [14:0]        step;
    } ch_state_t;

    function automatic logic [7:0] step_factor(input logic [2:0] mag);
        logic [7:0] f;
        unique case (mag)
            3'd0, 3'd1, 3'd2, 3'd3: f = 8'd57;
            3'd4:                   f = 8'd77;
            3'd5:                   f = 8'd102;
            3'd6:                   f = 8'd128;
            default:                f = 8'd153;
        endcase
        return f;
    endfunction

endpackage

@@ rtl/adaptive_delta_pcm_decoder.sv @@
// ---------------------------------------------------------------------------
// adaptive_delta_pcm_decoder
// ADPCM-B decoder: one byte of two 4-bit codes in, two samples and their
// volume-scaled copies out, using one shared decode unit and one multiplier.
// ---------------------------------------------------------------------------
//  Channel | Ports                               | Moves
//  --------+-------------------------------------+------------------------------
//  input   | s_valid, s_ready, s_data            | one code byte per request
//  result  | m_valid, m_ready, m_data            | two samples plus scaled copies
//  config  | cfg_valid, cfg_ready, cfg_index/data| one register write per request
//
//  An item passes through accept, high nibble, low nibble and scale before the next
//  request is accepted; the single decode unit and single multiplier are shared by
//  these steps. The result register is loaded in the scale step once it is free.
//  Reset (aresetn low, synchronous) clears predictors to 0, steps to 127,
//  mono mode and unity volumes. A stalled result holds in the output register;
//  the next request is taken meanwhile and waits in the scale step if needed.
// ---------------------------------------------------------------------------
`include "adaptive_delta_pcm_decoder_macros.svh"

module adaptive_delta_pcm_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  adpcmb_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output adpcmb_pkg::out_item_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import adpcmb_pkg::*;

    // Sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DEC_HI = 2'd1;
    localparam logic [1:0] ST_DEC_LO = 2'd2;
    localparam logic [1:0] ST_SCALE  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers
    logic       stereo_mode_reg;
    logic [7:0] volume_left_reg;
    logic [7:0] volume_right_reg;

    // Item in flight
    in_item_t   item_reg;
    logic       mode_reg;
    logic signed [15:0] sample_a_reg;
    logic signed [15:0] sample_b_reg;
    logic signed [23:0] scaled_a_reg;

    // Channel state
    ch_state_t  ch0_reg;
    ch_state_t  ch1_reg;

    // Result register
    out_item_t  out_reg;
    logic       out_valid_reg, out_valid_next;

    // Shared unit hookup
    ch_state_t  unit_cur;
    ch_state_t  unit_upd;
    logic [3:0] unit_code;
    logic       use_ch1;
    logic signed [15:0] mul_sample;
    logic [7:0]         mul_volume;
    logic signed [23:0] mul_result;

    logic in_fire;
    logic out_fire;
    logic load_out;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = out_valid_reg && m_ready;
    // Move the finished item into the result register once it is free.
    assign load_out = (state_reg == ST_SCALE) && (!out_valid_reg || m_ready);

    // Stereo: low nibble goes to channel 1; mono keeps everything on channel 0.
    assign use_ch1   = (state_reg == ST_DEC_LO) && mode_reg;
    assign unit_cur  = use_ch1 ? ch1_reg : ch0_reg;
    assign unit_code = (state_reg == ST_DEC_HI) ? item_reg.code_byte[7:4]
                                                : item_reg.code_byte[3:0];

    adpcmb_nibble_unit u_nibble (
        .cur  (unit_cur),
        .code (unit_code),
        .upd  (unit_upd)
    );

    // Multiplier: first sample during the low-nibble step, second in the scale step.
    assign mul_sample = (state_reg == ST_SCALE) ? sample_b_reg : sample_a_reg;
    assign mul_volume = ((state_reg == ST_SCALE) && mode_reg) ? volume_right_reg
                                                              : volume_left_reg;

    adpcmb_scaler u_scaler (
        .sample (mul_sample),
        .volume (mul_volume),
        .scaled (mul_result)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_DEC_HI;
                end
            end
            ST_DEC_HI: state_next = ST_DEC_LO;
            ST_DEC_LO: state_next = ST_SCALE;
            ST_SCALE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            stereo_mode_reg  <= 1'b0;
            volume_left_reg  <= 8'd1;
            volume_right_reg <= 8'd1;
            ch0_reg          <= '{pred: 16'sd0, step: STEP_MIN};
            ch1_reg          <= '{pred: 16'sd0, step: STEP_MIN};
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            // Ignore writes to indexes past the register list.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_STEREO_MODE:  stereo_mode_reg  <= cfg_data[0];
                    REG_VOLUME_LEFT:  volume_left_reg  <= cfg_data;
                    REG_VOLUME_RIGHT: volume_right_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Write back whichever channel the shared unit worked on.
            if (state_reg == ST_DEC_HI || state_reg == ST_DEC_LO) begin
                if (use_ch1) begin
                    ch1_reg <= unit_upd;
                end else begin
                    ch0_reg <= unit_upd;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg <= s_data;
            mode_reg <= stereo_mode_reg;
        end
        if (state_reg == ST_DEC_HI) begin
            sample_a_reg <= unit_upd.pred;
        end
        if (state_reg == ST_DEC_LO) begin
            sample_b_reg <= unit_upd.pred;
            scaled_a_reg <= mul_result;
        end
        if (load_out) begin
            out_reg.sample_first  <= sample_a_reg;
            out_reg.sample_second <= sample_b_reg;
            out_reg.scaled_first  <= scaled_a_reg;
            out_reg.scaled_second <= mul_result;
            out_reg.block_done    <= item_reg.end_of_block;
        end
    end

    // Checks
    `ADPCMB_ASSERT_NEXT(a_accept_starts_decode, aclk, aresetn, in_fire, state_reg == ST_DEC_HI, "accepted request did not start decode")
    `ADPCMB_ASSERT_ALWAYS(a_step_in_range, aclk, aresetn, ch0_reg.step >= STEP_MIN && ch0_reg.step <= STEP_MAX && ch1_reg.step >= STEP_MIN && ch1_reg.step <= STEP_MAX, "step size out of range")
    `ADPCMB_ASSERT_NEXT(a_scale_waits, aclk, aresetn, state_reg == ST_SCALE && out_valid_reg && !m_ready, state_reg == ST_SCALE && out_valid_reg, "finished item dropped while result stalled")

endmodule

@@ rtl/adpcmb_nibble_unit.sv @@
// ---------------------------------------------------------------------------
// adpcmb_nibble_unit
// Shared decode unit: applies one 4-bit code to one channel's state.
// ---------------------------------------------------------------------------
module adpcmb_nibble_unit (
    input  adpcmb_pkg::ch_state_t cur,
    input  logic [3:0]            code,
    output adpcmb_pkg::ch_state_t upd
);
    import adpcmb_pkg::*;

    logic [2:0]         mag;
    logic [3:0]         mult;
    logic [18:0]        diff_prod;
    logic [15:0]        diff;
    logic signed [17:0] pred_wide;
    logic signed [17:0] diff_wide;
    logic signed [17:0] pred_sum;
    logic [22:0]        step_prod;
    logic [16:0]        step_raw;

    assign mag       = code[2:0];
    assign mult      = {mag, 1'b1};
    assign diff_prod = 19'(mult) * 19'(cur.step);
    assign diff      = diff_prod[18:3];
    assign pred_wide = 18'(cur.pred);
    assign diff_wide = $signed({2'b00, diff});
    assign pred_sum  = code[3] ? (pred_wide - diff_wide) : (pred_wide + diff_wide);

    assign step_prod = 23'(cur.step) * 23'(step_factor(mag));
    assign step_raw  = step_prod[22:6];

    always_comb begin
        priority if (pred_sum < -18'sd32768) begin
            upd.pred = -16'sd32768;
        end else if (pred_sum > 18'sd32767) begin
            upd.pred = 16'sd32767;
        end else begin
            upd.pred = pred_sum[15:0];
        end

        priority if (step_raw < 17'(STEP_MIN)) begin
            upd.step = STEP_MIN;
        end else if (step_raw > 17'(STEP_MAX)) begin
            upd.step = STEP_MAX;
        end else begin
            upd.step = step_raw[14:0];
        end
    end

endmodule

@@ rtl/adpcmb_scaler.sv @@
// ---------------------------------------------------------------------------
// adpcmb_scaler
// Shared volume multiplier: signed sample times unsigned volume.
// ---------------------------------------------------------------------------
module adpcmb_scaler (
    input  logic signed [15:0] sample,
    input  logic [7:0]         volume,
    output logic signed [23:0] scaled
);
    logic signed [24:0] product;

    assign product = 25'(sample) * $signed({17'd0, volume});
    assign scaled  = product[23:0];

endmodule
